### sv/swarq_pkg.sv
package swarq_pkg;

  localparam int WindowSize = 3;
  localparam int MaxPackets = 1024;
  localparam int SeqW       = 11;
  localparam int MapAw      = $clog2(MaxPackets);
  localparam int OutW       = 2;
  localparam int DataW      = 16;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_HANDSHAKE = 2'd1,
    PH_TRANSFER  = 2'd2,
    PH_DONE      = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HS_SEND,
    ST_HS_ACK,
    ST_RD_ACK,
    ST_MARK,
    ST_RD_BASE,
    ST_PASS,
    ST_RESEND,
    ST_SEND,
    ST_DONE
  } ctrl_state_e;

  // what the output register is loaded with
  typedef enum logic [1:0] {
    EM_HANDSHAKE = 2'd0,
    EM_BASE      = 2'd1,
    EM_NEXT      = 2'd2,
    EM_DONE      = 2'd3
  } emit_kind_e;

  typedef struct packed {
    logic       in_load;
    logic       clr_step;
    logic       rd_ack;
    logic       rd_base;
    logic       mark;
    logic       hs_init;
    logic       slide;
    logic       emit;
    emit_kind_e kind;
    logic       retx;
    logic       last;
  } swarq_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic ack_new;
    logic ack_is_base;
    logic base_acked;
    logic out_lt_win;
    logic out_zero;
    logic out_one;
    logic nts_done;
    logic send_last;
    logic slot_free;
  } swarq_stat_t;

endpackage

### sv/sliding_window_arq_sender.sv
// Sender side of a windowed ARQ link. Each input transaction is an event
// (tuser: 0 start, 1 ack with the sequence in tdata, 2 timeout); each output
// transaction is a sequence to transmit with a retransmit flag, or the done
// report, with tlast on the final result of the event. After reset the
// 1024-entry ack bitmap is cleared one entry per cycle, and no event is taken
// until it is clear (configuration writes are taken throughout). Then the
// controller takes one event at a time: an ignored event is dropped, a start
// or handshake timeout emits its handshake send, and the handshake ack, a
// transfer ack or a transfer timeout runs a window pass whose results (at most
// four) go into the output register, each once the register is free. On a
// transfer ack the bitmap's registered read port is read once for the acked
// sequence and once for the base.
module sliding_window_arq_sender (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,    // total_packets
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [10:0] ack_seq
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [10:0] send_seq
  output logic [1:0]  m_axis_tuser,   // [0] is_retransmit, [1] all_done
  output logic        m_axis_tlast
);
  import swarq_pkg::*;

  swarq_cmd_t      cmd;
  swarq_stat_t     st;
  logic [SeqW-1:0] out_seq;
  logic            out_retx;
  logic            out_done;

  swarq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  swarq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_seq_i    (s_axis_tdata[SeqW-1:0]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_seq_o   (out_seq),
    .out_retx_o  (out_retx),
    .out_done_o  (out_done),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .st_o        (st)
  );

  assign m_axis_tdata = {{(DataW-SeqW){1'b0}}, out_seq};
  assign m_axis_tuser = {out_done, out_retx};

endmodule

### sv/swarq_ctrl.sv
module swarq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             in_op_i,
  output logic                   in_ready_o,
  input  swarq_pkg::swarq_stat_t st_i,
  output swarq_pkg::swarq_cmd_t  cmd_o
);
  import swarq_pkg::*;

  ctrl_state_e state_q, state_d;
  phase_e      phase_q, phase_d;
  op_e         op_q, op_d;
  logic        resend_q, resend_d;
  logic        slide_q, slide_d;
  logic        send_q, send_d;
  logic        done_q, done_d;

  logic        timeout;
  logic        rs, sl, sd, dn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      phase_q  <= PH_IDLE;
      op_q     <= OP_START;
      resend_q <= 1'b0;
      slide_q  <= 1'b0;
      send_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      op_q     <= op_d;
      resend_q <= resend_d;
      slide_q  <= slide_d;
      send_q   <= send_d;
      done_q   <= done_d;
    end
  end

  // window pass plan, evaluated once the base's ack bit is back
  always_comb begin
    timeout = (op_q == OP_TIMEOUT);
    rs      = timeout ? !st_i.base_acked : resend_q;
    sl      = st_i.out_lt_win && st_i.base_acked && !st_i.out_zero;
    sd      = st_i.out_lt_win && !sl && !st_i.nts_done;
    dn      = st_i.nts_done && (sl ? st_i.out_one : st_i.out_zero);
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    op_d       = op_q;
    resend_d   = resend_q;
    slide_d    = slide_q;
    send_d     = send_q;
    done_d     = done_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = !st_i.clr_done;
        if (st_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          op_d          = op_e'(in_op_i);
          case (phase_q)
            PH_IDLE: begin
              if (in_op_i == OP_START) state_d = ST_HS_SEND;
            end
            PH_HANDSHAKE: begin
              if (in_op_i == OP_TIMEOUT) state_d = ST_HS_SEND;
              else if (in_op_i == OP_ACK) state_d = ST_HS_ACK;
            end
            PH_TRANSFER: begin
              if (in_op_i == OP_ACK) state_d = ST_RD_ACK;
              else if (in_op_i == OP_TIMEOUT) state_d = ST_RD_BASE;
            end
            default: ;
          endcase
        end
      end
      ST_HS_SEND: begin
        if (st_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EM_HANDSHAKE;
          cmd_o.retx = (op_q == OP_TIMEOUT);
          cmd_o.last = 1'b1;
          phase_d    = PH_HANDSHAKE;
          state_d    = ST_IDLE;
        end
      end
      ST_HS_ACK: begin
        cmd_o.hs_init = 1'b1;
        phase_d       = PH_TRANSFER;
        resend_d      = 1'b0;
        state_d       = ST_RD_BASE;
      end
      ST_RD_ACK: begin
        cmd_o.rd_ack = 1'b1;
        state_d      = ST_MARK;
      end
      ST_MARK: begin
        cmd_o.mark = st_i.ack_new;
        resend_d   = st_i.ack_new && !st_i.ack_is_base;
        state_d    = ST_RD_BASE;
      end
      ST_RD_BASE: begin
        cmd_o.rd_base = 1'b1;
        state_d       = ST_PASS;
      end
      ST_PASS: begin
        slide_d = sl;
        send_d  = sd;
        done_d  = dn;
        if (rs) begin
          state_d = ST_RESEND;
        end else begin
          cmd_o.slide = sl;
          if (sd) state_d = ST_SEND;
          else if (dn) state_d = ST_DONE;
          else state_d = ST_IDLE;
        end
      end
      ST_RESEND: begin
        if (st_i.slot_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.kind  = EM_BASE;
          cmd_o.retx  = 1'b1;
          cmd_o.last  = !(send_q || done_q);
          // slide after the old base went out
          cmd_o.slide = slide_q;
          if (send_q) state_d = ST_SEND;
          else if (done_q) state_d = ST_DONE;
          else state_d = ST_IDLE;
        end
      end
      ST_SEND: begin
        if (st_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EM_NEXT;
          cmd_o.last = st_i.send_last;
          if (st_i.send_last) state_d = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (st_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EM_DONE;
          cmd_o.last = 1'b1;
          phase_d    = PH_DONE;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/swarq_dp.sv
module swarq_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [swarq_pkg::SeqW-1:0] cfg_wdata_i,
  input  logic [swarq_pkg::SeqW-1:0] in_seq_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [swarq_pkg::SeqW-1:0] out_seq_o,
  output logic                       out_retx_o,
  output logic                       out_done_o,
  output logic                       out_last_o,
  input  swarq_pkg::swarq_cmd_t      cmd_i,
  output swarq_pkg::swarq_stat_t     st_o
);
  import swarq_pkg::*;

  localparam logic [SeqW-1:0] MaxPk  = SeqW'(MaxPackets);
  localparam logic [SeqW-1:0] SeqOne = SeqW'(1);
  localparam logic [OutW-1:0] WinMax = OutW'(WindowSize);
  localparam logic [OutW-1:0] OutOne = OutW'(1);

  logic [SeqW-1:0]  total_q;
  logic [SeqW-1:0]  s_q;
  logic [SeqW-1:0]  base_q, base_d;
  logic [SeqW-1:0]  nts_q, nts_d;
  logic [OutW-1:0]  out_q, out_d;
  logic [MapAw:0]   clr_cnt_q;
  logic             rdata_q;
  logic             acked_mem [MaxPackets];

  logic             m_valid_q;
  logic [SeqW-1:0]  m_seq_q;
  logic             m_retx_q;
  logic             m_done_q;
  logic             m_last_q;

  logic [SeqW-1:0]  tot_eff;
  logic [SeqW-1:0]  s_m1, base_m1, nts_p1;
  logic             s_ok, base_in_map, slot_free;
  logic             mem_we, mem_wdata, rd_en;
  logic [MapAw-1:0] waddr, raddr;
  logic [SeqW-1:0]  em_seq;

  always_comb begin
    if (total_q == '0) tot_eff = SeqOne;
    else if (total_q > MaxPk) tot_eff = MaxPk;
    else tot_eff = total_q;
  end

  assign s_m1        = s_q - SeqOne;
  assign base_m1     = base_q - SeqOne;
  assign nts_p1      = nts_q + SeqOne;
  assign s_ok        = (s_q != '0) && (s_q <= tot_eff) && (s_q <= nts_q);
  assign base_in_map = (base_q != '0) && (base_q <= MaxPk);
  assign slot_free   = !m_valid_q || out_ready_i;

  always_comb begin
    st_o.clr_done    = clr_cnt_q[MapAw];
    st_o.ack_new     = s_ok && !rdata_q;
    st_o.ack_is_base = (s_q == base_q);
    st_o.base_acked  = !base_in_map || rdata_q;
    st_o.out_lt_win  = (out_q < WinMax);
    st_o.out_zero    = (out_q == '0);
    st_o.out_one     = (out_q == OutOne);
    st_o.nts_done    = (nts_q >= tot_eff);
    st_o.send_last   = (out_q == WinMax - OutOne) || (nts_p1 >= tot_eff);
    st_o.slot_free   = slot_free;
  end

  // ack bitmap: one write and one registered read port
  always_comb begin
    mem_we    = cmd_i.clr_step || cmd_i.mark || cmd_i.hs_init;
    mem_wdata = !cmd_i.clr_step;
    if (cmd_i.clr_step) waddr = clr_cnt_q[MapAw-1:0];
    else if (cmd_i.mark) waddr = s_m1[MapAw-1:0];
    else waddr = '0;
    rd_en = cmd_i.rd_ack || cmd_i.rd_base;
    raddr = cmd_i.rd_base ? base_m1[MapAw-1:0] : s_m1[MapAw-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) acked_mem[waddr] <= mem_wdata;
    if (rd_en) rdata_q <= acked_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + (MapAw+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= SeqOne;
    end else if (cfg_we_i) begin
      total_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) s_q <= in_seq_i;
  end

  // window counters; base + outstanding == sent + 1 at all times
  always_comb begin
    base_d = base_q;
    nts_d  = nts_q;
    out_d  = out_q;
    if (cmd_i.hs_init) begin
      base_d = SeqW'(2);
      nts_d  = SeqOne;
      out_d  = '0;
    end else if (cmd_i.mark && st_o.ack_is_base) begin
      base_d = base_q + SeqOne;
      if (out_q != '0) out_d = out_q - OutOne;
    end else if (cmd_i.slide) begin
      base_d = base_q + SeqOne;
      out_d  = out_q - OutOne;
    end else if (cmd_i.emit && cmd_i.kind == EM_NEXT) begin
      nts_d = nts_p1;
      out_d = out_q + OutOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= SeqOne;
      nts_q  <= '0;
      out_q  <= '0;
    end else begin
      base_q <= base_d;
      nts_q  <= nts_d;
      out_q  <= out_d;
    end
  end

  always_comb begin
    case (cmd_i.kind)
      EM_HANDSHAKE: em_seq = SeqOne;
      EM_BASE:      em_seq = base_q;
      EM_NEXT:      em_seq = nts_p1;
      EM_DONE:      em_seq = '0;
      default:      em_seq = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_seq_q  <= em_seq;
      m_retx_q <= cmd_i.retx;
      m_done_q <= (cmd_i.kind == EM_DONE);
      m_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_seq_o   = m_seq_q;
  assign out_retx_o  = m_retx_q;
  assign out_done_o  = m_done_q;
  assign out_last_o  = m_last_q;

`ifndef SYNTHESIS
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> slot_free)
    else $error("result loaded over an untaken one");

  a_window_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, base_q} + {{SeqW-OutW+1{1'b0}}, out_q}) == ({1'b0, nts_q} + (SeqW+1)'(1)))
    else $error("base, outstanding and sent count disagree");

  a_mark_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mark || cmd_i.hs_init || rd_en) |-> st_o.clr_done)
    else $error("bitmap used before clearing finished");

  a_clear_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(st_o.clr_done) |-> st_o.clr_done)
    else $error("clear pass restarted");

  a_out_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_q <= WinMax)
    else $error("outstanding above window");
`endif

endmodule

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import swarq_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [10:0] seq;
    logic        retx;
    logic        done;
    logic        last;
  } arq_send_t;

  // Tracks the sender's window and bitmap, and holds the sends it must emit.
  class arq_scoreboard;
    logic [10:0] total_reg;
    phase_e      phase;
    logic [10:0] base;
    logic [10:0] sent;
    int unsigned outstanding;
    bit          acked [MaxPackets];
    arq_send_t   event_sends [$];
    arq_send_t   pending_sends [$];
    int          errors;
    int          events;
    int          results;
    int          resends;
    int          done_seen;

    function new();
      total_reg   = 11'd1;
      phase       = PH_IDLE;
      base        = 11'd1;
      sent        = 11'd0;
      outstanding = 0;
      foreach (acked[k]) acked[k] = 1'b0;
    endfunction

    function int unsigned eff_total();
      if (total_reg == 0) return 1;
      if (total_reg > MaxPackets) return MaxPackets;
      return total_reg;
    endfunction

    // sequences outside the bitmap count as acknowledged
    function bit seq_acked(logic [10:0] s);
      if (s < 1 || s > MaxPackets) return 1'b1;
      return acked[s - 1];
    endfunction

    function void stage(logic [10:0] s, logic retx, logic done);
      arq_send_t t;
      if (event_sends.size() >= 4) return;
      t.seq  = s;
      t.retx = retx;
      t.done = done;
      t.last = 1'b0;
      event_sends.push_back(t);
    endfunction

    function void window_pass();
      int unsigned tot;
      tot = eff_total();
      if (outstanding < WindowSize) begin
        if (seq_acked(base) && outstanding > 0) begin
          base = base + 11'd1;
          outstanding--;
        end else begin
          while (outstanding < WindowSize && sent < tot) begin
            stage(sent + 11'd1, 1'b0, 1'b0);
            sent = sent + 11'd1;
            outstanding++;
          end
        end
      end
      if (outstanding == 0 && sent >= tot) begin
        phase = PH_DONE;
        stage(11'd0, 1'b0, 1'b1);
      end
    endfunction

    function void note_event(logic [1:0] op, logic [10:0] s);
      events++;
      event_sends.delete();
      case (phase)
        PH_IDLE: begin
          if (op == OP_START) begin
            stage(11'd1, 1'b0, 1'b0);
            phase = PH_HANDSHAKE;
          end
        end
        PH_HANDSHAKE: begin
          if (op == OP_TIMEOUT) begin
            stage(11'd1, 1'b1, 1'b0);
          end else if (op == OP_ACK) begin
            // any ack ends the handshake
            acked[0]    = 1'b1;
            base        = 11'd2;
            sent        = 11'd1;
            outstanding = 0;
            phase       = PH_TRANSFER;
            window_pass();
          end
        end
        PH_TRANSFER: begin
          if (op == OP_ACK) begin
            if (s >= 1 && s <= eff_total() && s <= sent) begin
              if (!acked[s - 1]) begin
                acked[s - 1] = 1'b1;
                if (s == base) begin
                  base = base + 11'd1;
                  if (outstanding > 0) outstanding--;
                end else begin
                  stage(base, 1'b1, 1'b0);
                end
              end
            end
            window_pass();
          end else if (op == OP_TIMEOUT) begin
            if (!seq_acked(base)) stage(base, 1'b1, 1'b0);
            window_pass();
          end
        end
        default: ;
      endcase
      if (event_sends.size() > 0) event_sends[event_sends.size() - 1].last = 1'b1;
      foreach (event_sends[k]) pending_sends.push_back(event_sends[k]);
    endfunction

    function void check_result(arq_send_t got);
      arq_send_t want;
      results++;
      if (got.retx) resends++;
      if (got.done) done_seen++;
      if (pending_sends.size() == 0) begin
        errors++;
        $display("%0t: unexpected send: seq=%0d retx=%0b done=%0b last=%0b", $time,
                 got.seq, got.retx, got.done, got.last);
        return;
      end
      want = pending_sends.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: want %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b (seq/retx/done/last)",
                 $time, want.seq, want.retx, want.done, want.last,
                 got.seq, got.retx, got.done, got.last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  bit            calm = 1'b0;
  arq_scoreboard sb = new();

  sliding_window_arq_sender uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result({m_axis_tdata[10:0], m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast});
    end
  end

  // receiver: random stall before each send transaction
  initial begin
    int stall;
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic write_total(logic [10:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.total_reg = value;
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_event(logic [1:0] op, logic [10:0] s);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, s};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_event(op, s);
  endtask

  // drain all sends, then give an event with no sends time to finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_sends.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // mostly acks inside the window, favoring the base so the window slides
  function automatic logic [10:0] pick_ack();
    int unsigned hi;
    int unsigned lo;
    hi = (sb.sent < sb.eff_total()) ? sb.sent : sb.eff_total();
    lo = sb.base;
    if (lo == 0 || lo > hi) return 11'($urandom_range(1, 1024));
    if ($urandom_range(0, 9) < 6) return 11'(lo);
    return 11'($urandom_range(lo, hi));
  endfunction

  task automatic random_events(int n, bit stop_after_done);
    int          k;
    int          tail;
    int unsigned r;
    logic [1:0]  op;
    logic [10:0] s;
    tail = 0;
    for (k = 0; k < n; k++) begin
      if (stop_after_done && sb.phase == PH_DONE) begin
        tail++;
        if (tail > 5) break;
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        op = OP_ACK;
        s  = pick_ack();
      end else if (r < 85) begin
        op = OP_TIMEOUT;
        s  = 11'($urandom);
      end else begin
        op = 2'($urandom_range(0, 3));
        s  = 11'($urandom);
      end
      send_event(op, s);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle: only a start has an effect; zero total acts as one
    write_total(11'd0);
    send_event(OP_ACK, 11'd5);
    send_event(OP_TIMEOUT, 11'd0);
    send_event(OpUnused, 11'h7ff);
    settle();

    // handshake with out-of-range total (acts as the maximum)
    write_total(11'h7ff);
    send_event(OP_START, 11'd0);
    send_event(OP_START, 11'd0);
    send_event(OP_TIMEOUT, 11'd0);
    send_event(OpUnused, 11'd0);
    send_event(OP_ACK, 11'h7ff);

    // bogus acks, out of order, duplicate, timeouts, in-order slide
    send_event(OP_ACK, 11'd0);
    send_event(OP_ACK, 11'h7ff);
    send_event(OP_ACK, 11'd1024);
    send_event(OP_ACK, 11'd3);
    send_event(OP_ACK, 11'd3);
    send_event(OP_TIMEOUT, 11'h555);
    send_event(OP_ACK, 11'd2);
    send_event(OP_TIMEOUT, 11'h2aa);
    send_event(OP_ACK, 11'd4);
    send_event(OP_START, 11'd4);
    send_event(OpUnused, 11'd4);
    settle();

    write_total(11'd1024);
    random_events(40, 1'b0);
    settle();

    calm = 1'b1;
    write_total(11'($urandom_range(200, 2047)));
    random_events(40, 1'b0);
    settle();

    // shrink the total to the sent count so the transfer drains to done
    calm = 1'b0;
    write_total(sb.sent);
    random_events(40, 1'b1);
    settle();

    $display("%0d events driven, %0d sends checked (%0d resends, %0d done reports)",
             sb.events, sb.results, sb.resends, sb.done_seen);
    if (sb.errors == 0 && sb.pending_sends.size() == 0) begin
      $display("sliding_window_arq_sender: match");
    end else begin
      $display("sliding_window_arq_sender: mismatch");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout with %0d sends outstanding", sb.pending_sends.size());
    $display("sliding_window_arq_sender: mismatch");
    $finish;
  end

endmodule

### files.f
sv/swarq_pkg.sv
sv/swarq_ctrl.sv
sv/swarq_dp.sv
sv/sliding_window_arq_sender.sv
verif/tb_top.sv
